// File: design/rrns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrns_pkg
// shared types, register indexes and crc-32 constants for the newest-copy
// selector of redundant status records
// ----------------------------------------------------------------------------
package rrns_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAGIC   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 1'b1;

    localparam logic [31:0] MAGIC_RESET   = 32'h424C_564C;
    localparam logic [15:0] VERSION_RESET = 16'd1;

    localparam logic [7:0] PERCENT_MAX  = 8'd100;
    localparam logic [7:0] CHARGING_MAX = 8'd1;

    // record layout: 20 bytes, the last four (crc field) taken as zero
    localparam int REC_BYTES  = 20;
    localparam int DATA_BITS  = 128;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // one copy after the checks, handed to the selector
    typedef struct packed {
        logic        ok;
        logic        last;
        logic [6:0]  percent;
        logic        charging;
        logic [31:0] sequence_nr;
    } t_cand;

    // one reflected crc step over a byte, used at elaboration only
    function automatic logic [31:0] crc_byte_f(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // crc of the whole record with every data bit zero, init and final xor
    function automatic logic [31:0] crc_zero_f();
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int k = 0; k < REC_BYTES; k++) begin
            c = crc_byte_f(c, 8'd0);
        end
        return c ^ 32'hFFFF_FFFF;
    endfunction

    // linear contribution of each data bit (crc is affine in the data)
    function automatic logic [DATA_BITS*32-1:0] crc_cols_f();
        logic [DATA_BITS*32-1:0] cols;
        logic [31:0]             c;
        logic [7:0]              d;
        cols = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            c = 32'd0;
            for (int k = 0; k < REC_BYTES; k++) begin
                d = (k == i / 8) ? (8'd1 << (i % 8)) : 8'd0;
                c = crc_byte_f(c, d);
            end
            cols[i*32 +: 32] = c;
        end
        return cols;
    endfunction

    localparam logic [31:0]             CRC_ZERO = crc_zero_f();
    localparam logic [DATA_BITS*32-1:0] CRC_COLS = crc_cols_f();

endpackage

// File: design/redundant_record_newest_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_record_newest_select
// picks the newest valid copy among a group of stored status records
// ----------------------------------------------------------------------------
// Takes one record copy per cycle and sustains one word per clock unless a
// group end waits on a full output register. A word accepted on the input is
// held in an input register; in the next cycle the checks (magic, version,
// percent and charging ranges, inverse word and the reflected crc-32 over the
// 20-byte record, built as one constant xor tree) run and the newest valid
// copy is kept, judged by a signed 32-bit wrapped difference of sequence
// numbers, the earlier copy winning ties. The copy flagged last_copy closes
// the group: its result is loaded into the output register and the kept state
// is cleared. Only the last copy of a group waits on a full output register,
// so a stalled output blocks the input only when a second group end arrives.
// The expected magic and version registers are written through the plain
// write port and must only change while no copy is in flight.
module redundant_record_newest_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rrns_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rrns_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input word
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [31:0]                       i_stored_magic,
    input  logic [15:0]                       i_stored_version,
    input  logic [7:0]                        i_stored_percent,
    input  logic [7:0]                        i_stored_charging,
    input  logic [31:0]                       i_stored_sequence,
    input  logic [31:0]                       i_stored_inverse,
    input  logic [31:0]                       i_stored_crc,
    input  logic                              i_last_copy,
    // result word
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [6:0]                        o_chosen_percent,
    output logic                              o_chosen_charging,
    output logic [31:0]                       o_chosen_sequence
);

    // configuration registers
    logic [31:0] r_expected_magic;
    logic [15:0] r_expected_version;

    // input register
    logic        r_in_valid;
    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [7:0]  r_percent;
    logic [7:0]  r_charging;
    logic [31:0] r_sequence;
    logic [31:0] r_inverse;
    logic [31:0] r_crc;
    logic        r_last;

    rrns_pkg::t_cand cand;
    logic            sel_accept;
    logic            fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic   <= rrns_pkg::MAGIC_RESET;
            r_expected_version <= rrns_pkg::VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rrns_pkg::REG_EXPECTED_MAGIC:   r_expected_magic   <= i_cfg_wdata;
                rrns_pkg::REG_EXPECTED_VERSION: r_expected_version <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // word in the input register moves on unless it closes a group while
    // the result register is still occupied
    assign fire       = r_in_valid && sel_accept;
    assign o_in_ready = !r_in_valid || sel_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_magic    <= i_stored_magic;
            r_version  <= i_stored_version;
            r_percent  <= i_stored_percent;
            r_charging <= i_stored_charging;
            r_sequence <= i_stored_sequence;
            r_inverse  <= i_stored_inverse;
            r_crc      <= i_stored_crc;
            r_last     <= i_last_copy;
        end
    end

    rrns_check u_check (
        .i_expected_magic   (r_expected_magic),
        .i_expected_version (r_expected_version),
        .i_magic            (r_magic),
        .i_version          (r_version),
        .i_percent          (r_percent),
        .i_charging         (r_charging),
        .i_sequence         (r_sequence),
        .i_inverse          (r_inverse),
        .i_crc              (r_crc),
        .i_last             (r_last),
        .o_cand             (cand)
    );

    rrns_select u_select (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_cand            (cand),
        .o_accept          (sel_accept),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_found           (o_found),
        .o_chosen_percent  (o_chosen_percent),
        .o_chosen_charging (o_chosen_charging),
        .o_chosen_sequence (o_chosen_sequence)
    );

endmodule

// File: design/rrns_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrns_check
// validity checks of one registered record copy: magic, version, ranges,
// inverse word and crc-32 as a flat xor tree
// ----------------------------------------------------------------------------
module rrns_check (
    input  logic [31:0]        i_expected_magic,
    input  logic [15:0]        i_expected_version,
    input  logic [31:0]        i_magic,
    input  logic [15:0]        i_version,
    input  logic [7:0]         i_percent,
    input  logic [7:0]         i_charging,
    input  logic [31:0]        i_sequence,
    input  logic [31:0]        i_inverse,
    input  logic [31:0]        i_crc,
    input  logic               i_last,
    output rrns_pkg::t_cand    o_cand
);

    logic [rrns_pkg::DATA_BITS-1:0] data;
    logic [31:0]                    crc_calc;
    logic                           fields_ok;

    // little-endian byte stream, bit 0 of byte 0 first
    assign data = {i_inverse, i_sequence, i_charging, i_percent, i_version, i_magic};

    always_comb begin
        crc_calc = rrns_pkg::CRC_ZERO;
        for (int i = 0; i < rrns_pkg::DATA_BITS; i++) begin
            if (data[i]) begin
                crc_calc = crc_calc ^ rrns_pkg::CRC_COLS[i*32 +: 32];
            end
        end
    end

    assign fields_ok = (i_magic == i_expected_magic)
                    && (i_version == i_expected_version)
                    && (i_percent <= rrns_pkg::PERCENT_MAX)
                    && (i_charging <= rrns_pkg::CHARGING_MAX)
                    && (i_inverse == ~i_sequence);

    assign o_cand.ok          = fields_ok && (i_crc == crc_calc);
    assign o_cand.last        = i_last;
    assign o_cand.percent     = i_percent[6:0];
    assign o_cand.charging    = i_charging[0];
    assign o_cand.sequence_nr = i_sequence;

endmodule

// File: design/rrns_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrns_select
// keeps the newest valid copy of a group and loads the result register
// when the last copy of the group goes through
// ----------------------------------------------------------------------------
module rrns_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rrns_pkg::t_cand    i_cand,
    output logic               o_accept,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [6:0]         o_chosen_percent,
    output logic               o_chosen_charging,
    output logic [31:0]        o_chosen_sequence
);

    logic        r_have, n_have;
    logic [31:0] r_best_seq, n_best_seq;
    logic [6:0]  r_best_pct, n_best_pct;
    logic        r_best_chg, n_best_chg;
    logic        r_out_valid;
    logic        r_found;
    logic [6:0]  r_pct;
    logic        r_chg;
    logic [31:0] r_seq;
    logic [31:0] diff;
    logic        take;

    // newer when the wrapped difference is positive
    assign diff = i_cand.sequence_nr - r_best_seq;
    assign take = i_cand.ok && (!r_have || ((diff != 32'd0) && !diff[31]));

    assign o_accept = !(i_cand.last && r_out_valid && !i_out_ready);

    always_comb begin
        n_have     = r_have;
        n_best_seq = r_best_seq;
        n_best_pct = r_best_pct;
        n_best_chg = r_best_chg;
        if (take) begin
            n_have     = 1'b1;
            n_best_seq = i_cand.sequence_nr;
            n_best_pct = i_cand.percent;
            n_best_chg = i_cand.charging;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_seq  <= '0;
            r_best_pct  <= '0;
            r_best_chg  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fire && i_cand.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_fire) begin
                if (i_cand.last) begin
                    r_have      <= 1'b0;
                    r_best_seq  <= '0;
                    r_best_pct  <= '0;
                    r_best_chg  <= 1'b0;
                end else begin
                    r_have      <= n_have;
                    r_best_seq  <= n_best_seq;
                    r_best_pct  <= n_best_pct;
                    r_best_chg  <= n_best_chg;
                end
            end
        end
    end

    // result payload, zero fields when nothing was valid
    always_ff @(posedge i_clk) begin
        if (i_fire && i_cand.last) begin
            r_found <= n_have;
            r_pct   <= n_have ? n_best_pct : 7'd0;
            r_chg   <= n_have ? n_best_chg : 1'b0;
            r_seq   <= n_have ? n_best_seq : 32'd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_chosen_percent  = r_pct;
    assign o_chosen_charging = r_chg;
    assign o_chosen_sequence = r_seq;

endmodule

// File: tb/tb_redundant_record_newest_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redundant_record_newest_select
// self-checking bench for the newest-valid-copy selector
// ----------------------------------------------------------------------------
// Feeds groups of status-record copies through the valid/ready input and
// checks each group result against a predictor kept in a small scoreboard
// class. The predictor runs its own bitwise crc-32 and the same validity and
// wrap-around newest rules. A directed set covers range limits, every failing
// check, ties and sequence wrap; random groups then mix sealed copies,
// single-field corruptions and noise under several magic/version settings,
// with random idle bursts on both sides and a final stretch without any.
// ----------------------------------------------------------------------------
module tb_redundant_record_newest_select;

    // one stored copy as driven on the input
    typedef struct {
        logic [31:0] magic;
        logic [15:0] version;
        logic [7:0]  percent;
        logic [7:0]  charging;
        logic [31:0] seq_nr;
        logic [31:0] inverse;
        logic [31:0] crc;
        logic        last;
    } t_copy;

    // one group result as seen on the output
    typedef struct {
        logic        found;
        logic [6:0]  percent;
        logic        charging;
        logic [31:0] seq_nr;
    } t_pick;

    // reflected crc-32 over the 20-byte little-endian record, crc field zero
    function automatic logic [31:0] copy_checksum(input logic [31:0] magic,
                                                  input logic [15:0] version,
                                                  input logic [7:0]  percent,
                                                  input logic [7:0]  charging,
                                                  input logic [31:0] seq_nr,
                                                  input logic [31:0] inverse);
        logic [159:0] rec;
        logic [31:0]  c;
        rec = {32'd0, inverse, seq_nr, charging, percent, version, magic};
        c = 32'hFFFF_FFFF;
        for (int k = 0; k < 20; k++) begin
            c = c ^ {24'd0, rec[8*k +: 8]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
            end
        end
        return ~c;
    endfunction

    // tracks the register copies, the running winner and the pending picks
    class pick_scoreboard;
        logic [31:0] magic_ref;
        logic [15:0] version_ref;
        bit          have_best;
        logic [31:0] best_seq;
        logic [6:0]  best_pct;
        logic        best_chg;
        t_pick       pending_picks[$];
        int unsigned mismatches;
        int unsigned copies;
        int unsigned groups;
        int unsigned found_groups;

        function new();
            magic_ref    = rrns_pkg::MAGIC_RESET;
            version_ref  = rrns_pkg::VERSION_RESET;
            have_best    = 0;
            best_seq     = '0;
            best_pct     = '0;
            best_chg     = 1'b0;
            mismatches   = 0;
            copies       = 0;
            groups       = 0;
            found_groups = 0;
        endfunction

        function void set_register(input logic [rrns_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [rrns_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rrns_pkg::REG_EXPECTED_MAGIC:   magic_ref   = data;
                rrns_pkg::REG_EXPECTED_VERSION: version_ref = data[15:0];
                default: ;
            endcase
        endfunction

        // an accepted copy: update the winner, close the group on the last one
        function void note_copy(input t_copy c);
            bit          ok;
            logic [31:0] diff;
            t_pick       p;
            copies++;
            ok = (c.magic == magic_ref) && (c.version == version_ref) &&
                 (c.percent <= 8'd100) && (c.charging <= 8'd1) &&
                 (c.inverse == ~c.seq_nr) &&
                 (c.crc == copy_checksum(c.magic, c.version, c.percent,
                                         c.charging, c.seq_nr, c.inverse));
            diff = c.seq_nr - best_seq;
            // newer means a positive signed wrapped difference
            if (ok && (!have_best || (diff != 32'd0 && !diff[31]))) begin
                have_best = 1;
                best_seq  = c.seq_nr;
                best_pct  = c.percent[6:0];
                best_chg  = c.charging[0];
            end
            if (c.last) begin
                p.found    = have_best;
                p.percent  = have_best ? best_pct : 7'd0;
                p.charging = have_best ? best_chg : 1'b0;
                p.seq_nr   = have_best ? best_seq : 32'd0;
                pending_picks.push_back(p);
                groups++;
                if (have_best) found_groups++;
                have_best = 0;
                best_seq  = '0;
                best_pct  = '0;
                best_chg  = 1'b0;
            end
        endfunction

        function void check_result(input t_pick got);
            t_pick exp;
            if (pending_picks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected word found=%0b pct=%0d chg=%0b seq=%h",
                             got.found, got.percent, got.charging, got.seq_nr);
                return;
            end
            exp = pending_picks.pop_front();
            if (got.found !== exp.found || got.percent !== exp.percent ||
                got.charging !== exp.charging || got.seq_nr !== exp.seq_nr) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp found=%0b pct=%0d chg=%0b seq=%h",
                             exp.found, exp.percent, exp.charging, exp.seq_nr);
                    $display("          got found=%0b pct=%0d chg=%0b seq=%h",
                             got.found, got.percent, got.charging, got.seq_nr);
                end
            end
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [rrns_pkg::CFG_INDEX_W-1:0]  i_cfg_index;
    logic [rrns_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [31:0]                       i_stored_magic;
    logic [15:0]                       i_stored_version;
    logic [7:0]                        i_stored_percent;
    logic [7:0]                        i_stored_charging;
    logic [31:0]                       i_stored_sequence;
    logic [31:0]                       i_stored_inverse;
    logic [31:0]                       i_stored_crc;
    logic                              i_last_copy;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_found;
    logic [6:0]                        o_chosen_percent;
    logic                              o_chosen_charging;
    logic [31:0]                       o_chosen_sequence;

    pick_scoreboard sb;
    bit             idle_en;
    int unsigned    out_stall_left;
    int unsigned    settings_done;

    redundant_record_newest_select u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_stored_magic    (i_stored_magic),
        .i_stored_version  (i_stored_version),
        .i_stored_percent  (i_stored_percent),
        .i_stored_charging (i_stored_charging),
        .i_stored_sequence (i_stored_sequence),
        .i_stored_inverse  (i_stored_inverse),
        .i_stored_crc      (i_stored_crc),
        .i_last_copy       (i_last_copy),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_found           (o_found),
        .o_chosen_percent  (o_chosen_percent),
        .o_chosen_charging (o_chosen_charging),
        .o_chosen_sequence (o_chosen_sequence)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // receiver: ready drops in random bursts while idling is enabled
    always @(negedge i_clk) begin
        if (out_stall_left != 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            out_stall_left <= $urandom_range(0, 18);
            i_out_ready    <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result words are checked at the accepting edge
    always @(posedge i_clk) begin
        t_pick got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.found    = o_found;
            got.percent  = o_chosen_percent;
            got.charging = o_chosen_charging;
            got.seq_nr   = o_chosen_sequence;
            sb.check_result(got);
        end
    end

    // a copy with matching magic, version, inverse word and crc under the current registers
    function automatic t_copy make_copy(input logic [31:0] seq_nr,
                                        input logic [7:0]  percent,
                                        input logic [7:0]  charging,
                                        input logic        last);
        t_copy c;
        c.magic    = sb.magic_ref;
        c.version  = sb.version_ref;
        c.percent  = percent;
        c.charging = charging;
        c.seq_nr   = seq_nr;
        c.inverse  = ~seq_nr;
        c.last     = last;
        c.crc      = copy_checksum(c.magic, c.version, c.percent, c.charging,
                                   c.seq_nr, c.inverse);
        return c;
    endfunction

    // recompute the crc so that only the edited field fails
    function automatic t_copy reseal(input t_copy c);
        t_copy r;
        r     = c;
        r.crc = copy_checksum(c.magic, c.version, c.percent, c.charging,
                              c.seq_nr, c.inverse);
        return r;
    endfunction

    // drive one word at the falling edge and hold it until accepted
    task automatic send_copy(input t_copy c);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_stored_magic    <= c.magic;
        i_stored_version  <= c.version;
        i_stored_percent  <= c.percent;
        i_stored_charging <= c.charging;
        i_stored_sequence <= c.seq_nr;
        i_stored_inverse  <= c.inverse;
        i_stored_crc      <= c.crc;
        i_last_copy       <= c.last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_copy(c);
        @(negedge i_clk);
    endtask

    // wait for every pending pick, then let the pipeline empty out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_picks.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // both registers, only while nothing is in flight
    task automatic write_registers(input logic [31:0] magic,
                                   input logic [31:0] version_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rrns_pkg::REG_EXPECTED_MAGIC;
        i_cfg_wdata <= magic;
        @(negedge i_clk);
        sb.set_register(rrns_pkg::REG_EXPECTED_MAGIC, magic);
        i_cfg_index <= rrns_pkg::REG_EXPECTED_VERSION;
        i_cfg_wdata <= version_word;
        @(negedge i_clk);
        sb.set_register(rrns_pkg::REG_EXPECTED_VERSION, version_word);
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic run_directed();
        t_copy c;
        // single-copy groups at the field extremes
        send_copy(make_copy(32'd0, 8'd0, 8'd0, 1'b1));
        send_copy(make_copy(32'hFFFF_FFFF, 8'd100, 8'd1, 1'b1));
        send_copy(make_copy(32'd7, 8'd101, 8'd0, 1'b1));
        send_copy(make_copy(32'd8, 8'd255, 8'd1, 1'b1));
        send_copy(make_copy(32'd9, 8'd50, 8'd2, 1'b1));
        send_copy(make_copy(32'd10, 8'd50, 8'd255, 1'b1));
        // each integrity check failing on its own
        c = make_copy(32'd11, 8'd40, 8'd1, 1'b1);
        c.inverse = c.inverse ^ 32'd1;
        send_copy(reseal(c));
        c = make_copy(32'd12, 8'd40, 8'd1, 1'b1);
        c.crc = c.crc ^ 32'h8000_0000;
        send_copy(c);
        c = make_copy(32'd13, 8'd40, 8'd0, 1'b1);
        c.magic = ~c.magic;
        send_copy(reseal(c));
        c = make_copy(32'd14, 8'd40, 8'd0, 1'b1);
        c.version = c.version ^ 16'h8000;
        send_copy(reseal(c));
        // wrap: 0 is newer than all ones, last copy has a bad crc
        send_copy(make_copy(32'hFFFF_FFFF, 8'd60, 8'd0, 1'b0));
        send_copy(make_copy(32'd0, 8'd61, 8'd1, 1'b0));
        c = make_copy(32'd5, 8'd62, 8'd0, 1'b1);
        c.crc = c.crc ^ 32'd1;
        send_copy(c);
        // tie keeps the earlier copy
        send_copy(make_copy(32'd5, 8'd10, 8'd0, 1'b0));
        send_copy(make_copy(32'd5, 8'd20, 8'd1, 1'b1));
        // half-range difference is not newer, one less is
        send_copy(make_copy(32'd0, 8'd1, 8'd0, 1'b0));
        send_copy(make_copy(32'h8000_0000, 8'd2, 8'd1, 1'b0));
        send_copy(make_copy(32'h7FFF_FFFF, 8'd3, 8'd0, 1'b1));
        // older copies never replace the winner
        send_copy(make_copy(32'd10, 8'd30, 8'd1, 1'b0));
        send_copy(make_copy(32'd9, 8'd31, 8'd0, 1'b0));
        send_copy(make_copy(32'd8, 8'd32, 8'd0, 1'b1));
    endtask

    // random groups: mostly sealed copies around one base sequence number
    task automatic run_random(input int unsigned n_items, input bit allow_idle);
        int unsigned sent;
        int unsigned gsize;
        int unsigned roll;
        logic [31:0] base;
        logic [31:0] seq_nr;
        logic [7:0]  pct;
        t_copy       c;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0)
                idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            gsize = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                 : $urandom_range(1, 6);
            base  = $urandom();
            for (int k = 0; k < gsize; k++) begin
                case ($urandom_range(0, 4))
                    0: seq_nr = base + $urandom_range(0, 6) - 32'd3;
                    1: seq_nr = base + 32'h8000_0000 + $urandom_range(0, 2) - 32'd1;
                    2: seq_nr = $urandom();
                    default: seq_nr = base + k;
                endcase
                case ($urandom_range(0, 9))
                    0: pct = 8'd0;
                    1: pct = 8'd100;
                    default: pct = 8'($urandom_range(0, 100));
                endcase
                c = make_copy(seq_nr, pct, 8'($urandom_range(0, 1)), k == gsize - 1);
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    // noise: every field random
                    c.magic    = $urandom();
                    c.version  = 16'($urandom());
                    c.percent  = 8'($urandom());
                    c.charging = 8'($urandom());
                    c.seq_nr   = $urandom();
                    c.inverse  = $urandom();
                    c.crc      = $urandom();
                end else if (roll < 26) begin
                    case ($urandom_range(0, 6))
                        0: c.magic    = c.magic ^ (32'd1 << $urandom_range(0, 31));
                        1: c.version  = c.version ^ (16'd1 << $urandom_range(0, 15));
                        2: c.percent  = 8'($urandom_range(101, 255));
                        3: c.charging = 8'($urandom_range(2, 255));
                        default: c.inverse = c.inverse ^ (32'd1 << $urandom_range(0, 31));
                    endcase
                    c = reseal(c);
                    // stale or flipped crc on an otherwise good copy
                    if ($urandom_range(0, 2) == 0) begin
                        c = make_copy(seq_nr, pct, 8'($urandom_range(0, 1)),
                                      k == gsize - 1);
                        c.crc = c.crc ^ (32'd1 << $urandom_range(0, 31));
                    end
                end
                send_copy(c);
                sent++;
            end
        end
    endtask

    initial begin
        sb                = new();
        idle_en           = 1'b1;
        out_stall_left    = 0;
        settings_done     = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_stored_magic    = '0;
        i_stored_version  = '0;
        i_stored_percent  = '0;
        i_stored_charging = '0;
        i_stored_sequence = '0;
        i_stored_inverse  = '0;
        i_stored_crc      = '0;
        i_last_copy       = 1'b0;
        i_out_ready       = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of the registers
        run_directed();
        run_random(230, 1'b1);
        drain();

        // all-zero magic and version, junk in the upper data bits
        write_registers(32'd0, {16'($urandom()), 16'd0});
        run_random(260, 1'b1);
        drain();

        // all-ones magic and version
        write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(260, 1'b1);
        drain();

        // random setting
        write_registers($urandom(), $urandom());
        run_random(260, 1'b1);
        drain();

        // back to the reset values, no idling on either side
        write_registers(rrns_pkg::MAGIC_RESET, {16'd0, rrns_pkg::VERSION_RESET});
        run_random(320, 1'b0);
        drain();
        repeat (10) @(negedge i_clk);

        $display("summary: %0d copies in %0d groups, %0d groups had a valid copy",
                 sb.copies, sb.groups, sb.found_groups);
        $display("summary: %0d register settings written, %0d mismatches",
                 settings_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_picks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #2000000;
        $display("timeout with %0d picks outstanding", sb.pending_picks.size());
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/rrns_pkg.sv
design/rrns_check.sv
design/rrns_select.sv
design/redundant_record_newest_select.sv
tb/tb_redundant_record_newest_select.sv
